[rtl/core/pah_pkg.sv]
`default_nettype none

package pah_pkg;

  localparam int TimeW    = 32;
  localparam int TempW    = 16;
  localparam int PresW    = 18;
  localparam int LevelW   = 13;
  localparam int GainW    = 4;
  localparam int DwellW   = 32;
  localparam int MsW      = 16;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 3;

  localparam logic signed [TempW-1:0] TempMin = -16'sd2000;
  localparam logic signed [TempW-1:0] TempMax = 16'sd6000;

  typedef enum logic [CfgIdxW-1:0] {
    RegBasePressure  = 3'd0,
    RegWarnOnLevel   = 3'd1,
    RegWarnOffLevel  = 3'd2,
    RegGain          = 3'd3,
    RegDwellMs       = 3'd4,
    RegAlertOnMs     = 3'd5,
    RegAlertPeriodMs = 3'd6,
    RegPublishHoldMs = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] base_pressure;
    logic [LevelW-1:0] warn_on_level;
    logic [LevelW-1:0] warn_off_level;
    logic [GainW-1:0]  gain;
    logic [DwellW-1:0] dwell_ms;
    logic [MsW-1:0]    alert_on_ms;
    logic [MsW-1:0]    alert_period_ms;
    logic [MsW-1:0]    publish_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_sample;
    logic [TimeW-1:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic stable_event;
    logic low_event;
    logic redraw;
    logic publish;
    logic alert_on;
    logic low_warning;
    logic signed [PresW-1:0] pressure;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/pah_eval.sv]
`default_nettype none

module pah_eval (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire pah_pkg::cfg_t    cfg_i,
  input  wire pah_pkg::sample_t sample_i,
  input  wire                 step_i,
  output pah_pkg::result_t    result_o
);
  import pah_pkg::*;

  logic signed [TempW-1:0] base_temp_q, base_temp_d, base_temp_use;
  logic                    base_vld_q;
  logic                    warn_q, warn_d;
  logic                    alert_q, alert_d;
  logic [TimeW-1:0]        alert_start_q, alert_start_d;
  logic [TimeW-1:0]        last_pub_q, last_pub_d;
  logic                    frozen_q, frozen_d;
  logic [TimeW-1:0]        low_since_q, low_since_d;
  logic                    low_vld_q, low_vld_d, low_sent_q, low_sent_d;
  logic [TimeW-1:0]        stab_since_q, stab_since_d;
  logic                    stab_vld_q, stab_vld_d, stab_sent_q, stab_sent_d;

  logic [TimeW-1:0]        now;
  logic signed [TempW:0]   diff;
  logic signed [TempW+GainW+1:0] prod;
  logic signed [PresW:0]   pres;
  logic                    low;
  logic [TimeW-1:0]        el_alert, el_alert2, el_pub, el_low, el_stab;
  logic                    started, publish, redraw, low_ev, stab_ev;

  assign now = sample_i.time_ms;

  always_comb begin
    base_temp_use = base_vld_q ? base_temp_q : sample_i.temp_sample;
    base_temp_d   = base_temp_use;
    diff = {sample_i.temp_sample[TempW-1], sample_i.temp_sample}
         - {base_temp_use[TempW-1], base_temp_use};
    prod = diff * $signed({1'b0, cfg_i.gain});
    pres = $signed({{(PresW+1-LevelW){1'b0}}, cfg_i.base_pressure})
         + prod[PresW:0];
    low  = pres <= $signed({{(PresW+1-LevelW){1'b0}}, cfg_i.warn_on_level});

    // hysteresis warning; the freeze drops when the warning clears
    warn_d   = warn_q;
    frozen_d = frozen_q;
    if (warn_q) begin
      if (pres >= $signed({{(PresW+1-LevelW){1'b0}}, cfg_i.warn_off_level})) begin
        warn_d   = 1'b0;
        frozen_d = 1'b0;
      end
    end else if (low) begin
      warn_d = 1'b1;
    end

    // alert on/off timing inside each repeat period
    el_alert      = now - alert_start_q;
    alert_d       = alert_q;
    alert_start_d = alert_start_q;
    started       = 1'b0;
    if (warn_d) begin
      if (!alert_q && (el_alert >= TimeW'(cfg_i.alert_period_ms))) begin
        alert_d       = 1'b1;
        alert_start_d = now;
        started       = 1'b1;
      end
    end
    el_alert2 = started ? '0 : el_alert;
    if (warn_d) begin
      if (alert_d && (el_alert2 >= TimeW'(cfg_i.alert_on_ms))) begin
        alert_d = 1'b0;
      end
    end else begin
      alert_d       = 1'b0;
      alert_start_d = '0;
    end

    // publish hold and dwell tracking
    el_pub       = now - last_pub_q;
    publish      = !(warn_d && (el_pub < TimeW'(cfg_i.publish_hold_ms)));
    redraw       = 1'b0;
    low_ev       = 1'b0;
    stab_ev      = 1'b0;
    last_pub_d   = last_pub_q;
    low_since_d  = low_since_q;
    low_vld_d    = low_vld_q;
    low_sent_d   = low_sent_q;
    stab_since_d = stab_since_q;
    stab_vld_d   = stab_vld_q;
    stab_sent_d  = stab_sent_q;
    el_low       = now - (low_vld_q ? low_since_q : now);
    el_stab      = now - (stab_vld_q ? stab_since_q : now);
    if (publish) begin
      last_pub_d = now;
      if (!(warn_d && frozen_d)) begin
        redraw = 1'b1;
        if (warn_d) begin
          frozen_d = 1'b1;
        end
      end
      if (low) begin
        stab_vld_d  = 1'b0;
        stab_sent_d = 1'b0;
        if (!low_vld_q) begin
          low_since_d = now;
          low_vld_d   = 1'b1;
        end
        if ((DwellW'(el_low) >= cfg_i.dwell_ms) && !low_sent_q) begin
          low_ev     = 1'b1;
          low_sent_d = 1'b1;
        end
      end else begin
        low_vld_d  = 1'b0;
        low_sent_d = 1'b0;
        if (!stab_vld_q) begin
          stab_since_d = now;
          stab_vld_d   = 1'b1;
        end
        if ((DwellW'(el_stab) >= cfg_i.dwell_ms) && !stab_sent_q) begin
          stab_ev     = 1'b1;
          stab_sent_d = 1'b1;
        end
      end
    end

    result_o.pressure     = pres[PresW-1:0];
    result_o.low_warning  = warn_d;
    result_o.alert_on     = alert_d;
    result_o.publish      = publish;
    result_o.redraw       = redraw;
    result_o.low_event    = low_ev;
    result_o.stable_event = stab_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_temp_q   <= '0;
      base_vld_q    <= 1'b0;
      warn_q        <= 1'b0;
      alert_q       <= 1'b0;
      alert_start_q <= '0;
      last_pub_q    <= '0;
      frozen_q      <= 1'b0;
      low_since_q   <= '0;
      low_vld_q     <= 1'b0;
      low_sent_q    <= 1'b0;
      stab_since_q  <= '0;
      stab_vld_q    <= 1'b0;
      stab_sent_q   <= 1'b0;
    end else if (step_i) begin
      base_temp_q   <= base_temp_d;
      base_vld_q    <= 1'b1;
      warn_q        <= warn_d;
      alert_q       <= alert_d;
      alert_start_q <= alert_start_d;
      last_pub_q    <= last_pub_d;
      frozen_q      <= frozen_d;
      low_since_q   <= low_since_d;
      low_vld_q     <= low_vld_d;
      low_sent_q    <= low_sent_d;
      stab_since_q  <= stab_since_d;
      stab_vld_q    <= stab_vld_d;
      stab_sent_q   <= stab_sent_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pressure_alarm_hysteresis_timer.sv]
// Low-pressure alarm on a stream of timestamped temperature samples. A sample
// marked bad or outside -20.00..60.00 C is dropped at the input and gives no
// result; every other sample gives exactly one result. Pressure is
// base_pressure + gain * (temp - first accepted temp), in centi-psi, and drives
// a hysteresis low warning, a timed alert output, a publish hold and one-shot
// low/stable events after the dwell time. One sample is taken per clock: it
// waits in the input register, and all state updates in the same cycle that
// moves it into the output register; throughput is one sample per cycle while
// the output is taken. Configuration writes belong to idle periods only.
`default_nettype none

module pressure_alarm_hysteresis_timer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [pah_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [pah_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [47:0]                   s_axis_tdata,  // temp_sample[15:0], time_ms[47:16]
  input  wire                          s_axis_tuser,  // sample_bad
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // pressure[17:0], low_warning[18], alert_on[19], publish[20], redraw[21],
  // low_event[22], stable_event[23]
  output logic [23:0]                  m_axis_tdata
);
  import pah_pkg::*;

  cfg_t    cfg_q;
  sample_t in_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    out_free, step, accept, sample_ok;
  logic signed [TempW-1:0] temp_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_pressure   <= LevelW'(1470);
      cfg_q.warn_on_level   <= LevelW'(1450);
      cfg_q.warn_off_level  <= LevelW'(1460);
      cfg_q.gain            <= GainW'(3);
      cfg_q.dwell_ms        <= DwellW'(180000);
      cfg_q.alert_on_ms     <= MsW'(3000);
      cfg_q.alert_period_ms <= MsW'(8000);
      cfg_q.publish_hold_ms <= MsW'(4000);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegBasePressure:  cfg_q.base_pressure   <= cfg_data_i[LevelW-1:0];
        RegWarnOnLevel:   cfg_q.warn_on_level   <= cfg_data_i[LevelW-1:0];
        RegWarnOffLevel:  cfg_q.warn_off_level  <= cfg_data_i[LevelW-1:0];
        RegGain:          cfg_q.gain            <= cfg_data_i[GainW-1:0];
        RegDwellMs:       cfg_q.dwell_ms        <= cfg_data_i[DwellW-1:0];
        RegAlertOnMs:     cfg_q.alert_on_ms     <= cfg_data_i[MsW-1:0];
        RegAlertPeriodMs: cfg_q.alert_period_ms <= cfg_data_i[MsW-1:0];
        RegPublishHoldMs: cfg_q.publish_hold_ms <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  assign temp_in   = s_axis_tdata[TempW-1:0];
  // drop bad and out-of-range requests right at the input
  assign sample_ok = !s_axis_tuser && (temp_in >= TempMin) && (temp_in <= TempMax);
  assign out_free  = !out_vld_q || m_axis_tready;
  assign step      = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= accept && sample_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && sample_ok) begin
      in_q.temp_sample <= temp_in;
      in_q.time_ms     <= s_axis_tdata[TempW+TimeW-1:TempW];
    end
  end

  pah_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (in_q),
    .step_i   (step),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

  a_events_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.low_event && res_q.stable_event))
    else $error("low and stable events in one result");

  a_held_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.publish) |->
      (!res_q.redraw && !res_q.low_event && !res_q.stable_event))
    else $error("held result redraws or fires an event");

  a_alert_needs_warning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.alert_on) |-> res_q.low_warning)
    else $error("alert on without low warning");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("evaluated request lost");

endmodule

`default_nettype wire
